// ===== src/snf_pkg.sv =====
// ----------------------------------------------------------------------------
// snf_pkg: shared types and constants of the simplex noise block
// Fixed-point constants in Q16, item and configuration records, sequencer
// states and the gradient index reduction.
// ----------------------------------------------------------------------------
`default_nettype none

package snf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 8;
  localparam int TABLE_SIZE  = 256;
  localparam int TW          = $clog2(TABLE_SIZE);

  // shared multiplier operand and product widths
  localparam int MW = 34;
  localparam int PW = 2 * MW;

  // Q16 constants
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int SKEW_2D   = 23988;   // (sqrt(3) - 1) / 2
  localparam int UNSKEW_2D = 13849;   // (3 - sqrt(3)) / 6
  localparam int HALF_Q    = 32768;   // 1/2
  localparam int THIRD_Q   = 21845;   // 1/3
  localparam int SIXTH_Q   = 10923;   // 1/6
  localparam int RAD_3D    = 39322;   // 0.6

  typedef enum logic [2:0] {
    REG_FREQUENCY,
    REG_LACUNARITY,
    REG_OCTAVE_GAIN,
    REG_OCTAVE_COUNT,
    REG_FRACTAL_SCALE,
    REG_THREE_DIM,
    REG_FRACTAL_MODE
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  typedef struct packed {
    logic               is_eval;
    logic [7:0]         tidx;
    logic [7:0]         tval;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } item_t;

  typedef struct packed {
    logic        valid;
    item_t       item;
  } front_out_t;

  typedef struct packed {
    logic [31:0] frequency;
    logic [23:0] lacunarity;
    logic [16:0] octave_gain;
    logic [3:0]  octave_count;
    logic [16:0] fractal_scale;
    logic        three_dim;
    logic        fractal;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCX, ST_SCY, ST_SCZ, ST_SCW, ST_AMPW, ST_OFFW, ST_SKEW,
    ST_CELL, ST_UNSK, ST_ORIG, ST_CSET, ST_RD0, ST_RD1, ST_RD2, ST_SQX,
    ST_SQY, ST_SQZ, ST_SQW, ST_TCHK, ST_T2, ST_T3, ST_T4, ST_T5,
    ST_T6, ST_CNXT, ST_OCT, ST_OCT2, ST_ACC, ST_NXO, ST_FSC, ST_OUT
  } state_e;

  // value mod 12 for an 8-bit value: reciprocal multiply, exact below 256
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [18:0] p;
    logic [7:0]  q;
    logic [7:0]  r;
    p = {11'b0, v} * 19'd171;
    q = 8'(p >> 11);
    r = v - 8'(q * 8'd12);
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/snf_front.sv =====
// ----------------------------------------------------------------------------
// snf_front: input queue and item decode
// Two-entry queue of accepted items; tags each item as a table load or a
// point evaluation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module snf_front import snf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode_i,
  input  wire logic [7:0]         table_index_i,
  input  wire logic [7:0]         table_value_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  output front_out_t              head_o,
  input  wire logic               pop_i
);

  item_t      slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       do_push, do_pop;

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  // present the oldest word
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
    end
  end

  // classify and store the word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q].is_eval <= (opcode_e'(opcode_i) == OP_EVAL);
      slot_q[wr_q].tidx    <= table_index_i;
      slot_q[wr_q].tval    <= table_value_i;
      slot_q[wr_q].cx      <= coord_x_i;
      slot_q[wr_q].cy      <= coord_y_i;
      slot_q[wr_q].cz      <= coord_z_i;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("input queue count overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
    else $error("input queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== src/snf_outq.sv =====
// ----------------------------------------------------------------------------
// snf_outq: result queue
// Two-entry queue that holds finished noise words until they are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module snf_outq import snf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic signed [19:0] data_i,
  output logic                    full_o,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [19:0]      noise_value_o
);

  logic signed [19:0] slot_q [2];
  logic [1:0]         cnt_q;
  logic               wr_q, rd_q;
  logic               do_push, do_pop;

  assign full_o        = (cnt_q == 2'd2);
  assign empty         = (cnt_q == 2'd0);
  assign do_push       = push_i && !full_o;
  assign do_pop        = pop && !empty;
  assign noise_value_o = slot_q[rd_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 2'd1;
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
    end
  end

  // store the word
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== src/snf_core.sv =====
// ----------------------------------------------------------------------------
// snf_core: noise evaluation back end
// Holds the permutation memory and sequences one shared multiplier through
// coordinate scaling, skewing, the corner kernels and the octave sum.
// ----------------------------------------------------------------------------
`default_nettype none

module snf_core import snf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire front_out_t         head_i,
  output logic                    pop_o,
  output logic                    res_push_o,
  output logic signed [19:0]      res_data_o,
  input  wire logic               res_full_i
);

  localparam logic signed [MW-1:0] ONE_M   = MW'(ONE_Q);
  localparam logic signed [MW-1:0] C1_2D   = MW'(UNSKEW_2D);
  localparam logic signed [MW-1:0] C2_2D   = MW'(2 * UNSKEW_2D);
  localparam logic signed [MW-1:0] C1_3D   = MW'(SIXTH_Q);
  localparam logic signed [MW-1:0] C2_3D   = MW'(THIRD_Q);
  localparam logic signed [MW-1:0] C3_3D   = MW'(HALF_Q);
  localparam logic signed [PW-1:0] RND_P   = PW'(1) <<< (FRAC_BITS - 1);

  state_e state_q, state_d;

  // permutation memory
  logic [7:0]    perm_mem [TABLE_SIZE];
  logic [TW-1:0] raddr;
  logic [7:0]    rdata_q;

  // multiplier
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod_q, mq_full;
  logic signed [39:0]   mq40;

  // working registers
  logic signed [31:0] raw_x_q, raw_y_q, raw_z_q;
  logic signed [31:0] xs_q, ys_q, zs_q;
  logic               first_q;
  logic signed [MW-1:0] amp_q;
  logic [3:0]         oidx_q;
  logic [7:0]         off_q;
  logic signed [20:0] ci_q, cj_q, ck_q;
  logic signed [MW-1:0] x0_q, y0_q, z0_q;
  logic [2:0]         o1_q, o2_q;
  logic [1:0]         cidx_q;
  logic signed [MW-1:0] dx_q, dy_q, dz_q;
  logic [7:0]         bx_q, by_q, bz_q;
  logic [3:0]         g_q;
  logic signed [39:0] t_q, n_q, sum_q, res_q;
  logic signed [MW-1:0] dot_q, oct_q;

  // combinational helpers
  logic [3:0]         noct;
  logic [4:0]         onext;
  logic               more_oct;
  logic [1:0]         last_c;
  logic signed [39:0] s40, xsum, ysum, zsum, u40, x0w, y0w, z0w;
  logic signed [22:0] ijk;
  logic [2:0]         cb;
  logic signed [MW-1:0] koff;
  logic signed [39:0] octv;

  function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
    if (v[PW-1]) return (&v[PW-1:31]) ? v[31:0] : 32'h8000_0000;
    return (|v[PW-1:31]) ? 32'h7FFF_FFFF : v[31:0];
  endfunction

  function automatic logic [19:0] sat20(input logic signed [39:0] v);
    if (v[39]) return (&v[39:19]) ? v[19:0] : 20'h80000;
    return (|v[39:19]) ? 20'h7FFFF : v[19:0];
  endfunction

  // gradient component: +d, -d or zero by the axis pattern of g
  function automatic logic signed [MW-1:0] gterm(input logic sel, input logic neg,
                                                 input logic signed [MW-1:0] d);
    if (!sel) return '0;
    return neg ? -d : d;
  endfunction

  // clamp the octave count
  always_comb begin
    if (cfg_i.octave_count == 4'd0) noct = 4'd1;
    else if (cfg_i.octave_count > 4'(MAX_OCTAVES)) noct = 4'(MAX_OCTAVES);
    else noct = cfg_i.octave_count;
  end
  assign onext    = 5'(oidx_q) + 5'd1;
  assign more_oct = (onext < 5'(noct));
  assign last_c   = cfg_i.three_dim ? 2'd3 : 2'd2;

  // rounded product
  assign mq_full = (prod_q + RND_P) >>> FRAC_BITS;
  assign mq40    = $signed(mq_full[39:0]);

  // cell and origin terms
  assign s40  = mq40;
  assign xsum = 40'(xs_q) + s40;
  assign ysum = 40'(ys_q) + s40;
  assign zsum = 40'(zs_q) + s40;
  assign ijk  = 23'(ci_q) + 23'(cj_q) + (cfg_i.three_dim ? 23'(ck_q) : 23'sd0);
  assign u40  = $signed(prod_q[39:0]);
  assign x0w  = 40'(xs_q) - (40'(ci_q) <<< FRAC_BITS) + u40;
  assign y0w  = 40'(ys_q) - (40'(cj_q) <<< FRAC_BITS) + u40;
  assign z0w  = 40'(zs_q) - (40'(ck_q) <<< FRAC_BITS) + u40;

  // corner offsets
  always_comb begin
    cb   = 3'b000;
    koff = '0;
    case (cidx_q)
      2'd0: begin
        cb   = 3'b000;
        koff = '0;
      end
      2'd1: begin
        cb   = o1_q;
        koff = cfg_i.three_dim ? C1_3D : C1_2D;
      end
      2'd2: begin
        cb   = cfg_i.three_dim ? o2_q : 3'b011;
        koff = cfg_i.three_dim ? C2_3D : C2_2D;
      end
      default: begin
        cb   = 3'b111;
        koff = C3_3D;
      end
    endcase
  end

  assign octv = cfg_i.three_dim ? ((n_q <<< 4) + 40'(HALF_Q))
                                : ((n_q <<< 5) + (n_q <<< 1) + n_q + 40'(HALF_Q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (head_i.valid && head_i.item.is_eval) state_d = ST_SCX;
      ST_SCX:  state_d = ST_SCY;
      ST_SCY:  state_d = ST_SCZ;
      ST_SCZ:  state_d = ST_SCW;
      ST_SCW:  state_d = ST_AMPW;
      ST_AMPW: state_d = ST_OFFW;
      ST_OFFW: state_d = ST_SKEW;
      ST_SKEW: state_d = ST_CELL;
      ST_CELL: state_d = ST_UNSK;
      ST_UNSK: state_d = ST_ORIG;
      ST_ORIG: state_d = ST_CSET;
      ST_CSET: state_d = cfg_i.three_dim ? ST_RD0 : ST_RD1;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQZ;
      ST_SQZ:  state_d = ST_SQW;
      ST_SQW:  state_d = ST_TCHK;
      ST_TCHK: state_d = t_q[39] ? ST_CNXT : ST_T2;
      ST_T2:   state_d = ST_T3;
      ST_T3:   state_d = ST_T4;
      ST_T4:   state_d = ST_T5;
      ST_T5:   state_d = ST_T6;
      ST_T6:   state_d = ST_CNXT;
      ST_CNXT: state_d = (cidx_q == last_c) ? ST_OCT : ST_CSET;
      ST_OCT:  state_d = ST_OCT2;
      ST_OCT2: begin
        if (!cfg_i.fractal) state_d = ST_OUT;
        else if (oidx_q == 4'd0) state_d = ST_NXO;
        else state_d = ST_ACC;
      end
      ST_ACC:  state_d = ST_NXO;
      ST_NXO:  state_d = more_oct ? ST_SCX : ST_FSC;
      ST_FSC:  state_d = ST_OUT;
      ST_OUT:  if (!res_full_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // multiplier operands, memory address, handshakes
  always_comb begin
    ma         = '0;
    mb         = '0;
    raddr      = '0;
    pop_o      = 1'b0;
    res_push_o = 1'b0;
    res_data_o = $signed(sat20(res_q));
    case (state_q)
      ST_IDLE: pop_o = head_i.valid;
      ST_SCX: begin
        ma = first_q ? MW'(raw_x_q) : MW'(xs_q);
        mb = first_q ? $signed({2'b00, cfg_i.frequency}) : $signed({10'b0, cfg_i.lacunarity});
      end
      ST_SCY: begin
        ma = first_q ? MW'(raw_y_q) : MW'(ys_q);
        mb = first_q ? $signed({2'b00, cfg_i.frequency}) : $signed({10'b0, cfg_i.lacunarity});
      end
      ST_SCZ: begin
        ma = first_q ? MW'(raw_z_q) : MW'(zs_q);
        mb = first_q ? $signed({2'b00, cfg_i.frequency}) : $signed({10'b0, cfg_i.lacunarity});
      end
      ST_SCW: begin
        ma = amp_q;
        mb = $signed({17'b0, cfg_i.octave_gain});
      end
      ST_AMPW: raddr = TW'(oidx_q);
      ST_SKEW: begin
        ma = MW'(xs_q) + MW'(ys_q) + (cfg_i.three_dim ? MW'(zs_q) : '0);
        mb = cfg_i.three_dim ? MW'(THIRD_Q) : MW'(SKEW_2D);
      end
      ST_UNSK: begin
        ma = MW'(ijk);
        mb = cfg_i.three_dim ? MW'(SIXTH_Q) : MW'(UNSKEW_2D);
      end
      ST_RD0: raddr = bz_q + off_q;
      ST_RD1: raddr = by_q + (cfg_i.three_dim ? rdata_q : off_q);
      ST_RD2: raddr = bx_q + rdata_q;
      ST_SQX: begin
        ma = dx_q;
        mb = dx_q;
      end
      ST_SQY: begin
        ma = dy_q;
        mb = dy_q;
      end
      ST_SQZ: begin
        ma = dz_q;
        mb = dz_q;
      end
      ST_TCHK, ST_T3: begin
        ma = t_q[MW-1:0];
        mb = t_q[MW-1:0];
      end
      ST_T5: begin
        ma = t_q[MW-1:0];
        mb = dot_q;
      end
      ST_OCT2: begin
        ma = oct_q;
        mb = amp_q;
      end
      ST_NXO: begin
        ma = sum_q[MW-1:0];
        mb = $signed({17'b0, cfg_i.fractal_scale});
      end
      ST_OUT: res_push_o = !res_full_i;
      default: ;
    endcase
  end

  // hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && head_i.valid && !head_i.item.is_eval) begin
      perm_mem[head_i.item.tidx] <= head_i.item.tval;
    end
    rdata_q <= perm_mem[raddr];
  end

  // register each product
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(ma) * PW'(mb);
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        raw_x_q <= head_i.item.cx;
        raw_y_q <= head_i.item.cy;
        raw_z_q <= head_i.item.cz;
        first_q <= 1'b1;
        amp_q   <= ONE_M;
        oidx_q  <= 4'd0;
      end
      ST_SCY: xs_q <= $signed(sat32(mq_full));
      ST_SCZ: ys_q <= $signed(sat32(mq_full));
      ST_SCW: zs_q <= $signed(sat32(mq_full));
      ST_AMPW: if (!first_q) amp_q <= mq_full[MW-1:0];
      ST_OFFW: off_q <= cfg_i.fractal ? rdata_q : 8'd0;
      ST_CELL: begin
        ci_q <= xsum[36:16];
        cj_q <= ysum[36:16];
        ck_q <= zsum[36:16];
      end
      ST_ORIG: begin
        x0_q   <= x0w[MW-1:0];
        y0_q   <= y0w[MW-1:0];
        z0_q   <= z0w[MW-1:0];
        cidx_q <= 2'd0;
        n_q    <= '0;
        // simplex traversal order, bits are {k, j, i}
        if (!cfg_i.three_dim) begin
          o1_q <= (x0w > y0w) ? 3'b001 : 3'b010;
          o2_q <= 3'b011;
        end else if (x0w >= y0w) begin
          if (y0w >= z0w) begin
            o1_q <= 3'b001;
            o2_q <= 3'b011;
          end else if (x0w >= z0w) begin
            o1_q <= 3'b001;
            o2_q <= 3'b101;
          end else begin
            o1_q <= 3'b100;
            o2_q <= 3'b101;
          end
        end else begin
          if (y0w < z0w) begin
            o1_q <= 3'b100;
            o2_q <= 3'b110;
          end else if (x0w < z0w) begin
            o1_q <= 3'b010;
            o2_q <= 3'b110;
          end else begin
            o1_q <= 3'b010;
            o2_q <= 3'b011;
          end
        end
      end
      ST_CSET: begin
        dx_q <= x0_q - (cb[0] ? ONE_M : '0) + koff;
        dy_q <= y0_q - (cb[1] ? ONE_M : '0) + koff;
        dz_q <= cfg_i.three_dim ? (z0_q - (cb[2] ? ONE_M : '0) + koff) : '0;
        bx_q <= ci_q[7:0] + {7'b0, cb[0]};
        by_q <= cj_q[7:0] + {7'b0, cb[1]};
        bz_q <= ck_q[7:0] + {7'b0, cb[2]};
      end
      ST_SQX: g_q <= mod12(rdata_q);
      ST_SQY: t_q <= 40'(RAD_3D) - (cfg_i.three_dim ? 40'sd0 : 40'(RAD_3D - HALF_Q)) - mq40;
      ST_SQZ: t_q <= t_q - mq40;
      ST_SQW: begin
        t_q   <= t_q - mq40;
        dot_q <= gterm(!g_q[3], g_q[0], dx_q)
               + gterm(!g_q[2] || g_q[3], g_q[3] ? g_q[0] : g_q[1], dy_q)
               + gterm(g_q[2] || g_q[3], g_q[1], dz_q);
      end
      ST_T2, ST_T4: t_q <= mq40;
      ST_T6: n_q <= n_q + mq40;
      ST_CNXT: cidx_q <= cidx_q + 2'd1;
      ST_OCT: oct_q <= octv[MW-1:0];
      ST_OCT2: begin
        if (!cfg_i.fractal) res_q <= 40'(oct_q);
        else if (oidx_q == 4'd0) sum_q <= 40'(oct_q);
      end
      ST_ACC: sum_q <= sum_q + mq40;
      ST_NXO: begin
        if (more_oct) begin
          oidx_q  <= onext[3:0];
          first_q <= 1'b0;
        end
      end
      ST_FSC: res_q <= mq40;
      default: ;
    endcase
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE)) else $error("item taken while busy");

  a_eval_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.item.is_eval) |=> (state_q == ST_SCX))
    else $error("evaluation did not start after its item was taken");

  a_corner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CSET) |-> (cidx_q <= last_c))
    else $error("corner index past last corner");

  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && res_full_i) |=> (state_q == ST_OUT))
    else $error("result dropped while queue full");

endmodule

`default_nettype wire

// ===== src/simplex_noise_fractal_top.sv =====
// ----------------------------------------------------------------------------
// simplex_noise_fractal_top: 2D/3D simplex noise with octave sum
// Configuration registers, input queue, sequenced noise back end and
// result queue.
//
//   channel   handshake                 payload
//   -------   -----------------------   ----------------------------------
//   input     push / full               opcode, table_index/value, coord_*
//   result    empty / pop               noise_value
//   config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A load item is written into the table as it is taken. A point is worked
// through octave by octave, scaling included, with fewer steps when a
// corner lies outside its radius, then the final scale in fractal mode and
// the output; the one shared multiplier and the single table read port serialise this.
// Reset clears queues, sequencer and configuration; table entries hold no
// reset value. The input queue keeps taking items while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module simplex_noise_fractal_top import snf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode_i,
  input  wire logic [7:0]         table_index_i,
  input  wire logic [7:0]         table_value_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [19:0]      noise_value_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);

  cfg_t               cfg_q;
  front_out_t         head;
  logic               core_pop;
  logic               res_push;
  logic signed [19:0] res_data;
  logic               res_full;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frequency     <= 32'h0001_0000;
      cfg_q.lacunarity    <= 24'h02_0000;
      cfg_q.octave_gain   <= 17'h0_8000;
      cfg_q.octave_count  <= 4'd1;
      cfg_q.fractal_scale <= 17'h1_0000;
      cfg_q.three_dim     <= 1'b0;
      cfg_q.fractal       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FREQUENCY:     cfg_q.frequency     <= cfg_data_i;
        REG_LACUNARITY:    cfg_q.lacunarity    <= cfg_data_i[23:0];
        REG_OCTAVE_GAIN:   cfg_q.octave_gain   <= cfg_data_i[16:0];
        REG_OCTAVE_COUNT:  cfg_q.octave_count  <= cfg_data_i[3:0];
        REG_FRACTAL_SCALE: cfg_q.fractal_scale <= cfg_data_i[16:0];
        REG_THREE_DIM:     cfg_q.three_dim     <= cfg_data_i[0];
        REG_FRACTAL_MODE:  cfg_q.fractal       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  snf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .head_o        (head),
    .pop_i         (core_pop)
  );

  snf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .pop_o      (core_pop),
    .res_push_o (res_push),
    .res_data_o (res_data),
    .res_full_i (res_full)
  );

  snf_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (res_push),
    .data_i        (res_data),
    .full_o        (res_full),
    .empty         (empty),
    .pop           (pop),
    .noise_value_o (noise_value_o)
  );

endmodule

`default_nettype wire
